// ===== hdl/affine_matrix_vertex_transform_top_macros.svh =====
// Assertion macros for the affine matrix vertex transform checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef AFFINE_MATRIX_VERTEX_TRANSFORM_TOP_MACROS_SVH
`define AFFINE_MATRIX_VERTEX_TRANSFORM_TOP_MACROS_SVH

// Checked only while out of reset
`define AMVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define AMVT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/amvt_pkg.sv =====
// Shared types, constants and saturation helper for the vertex transform.
// No dependencies.
package amvt_pkg;

  localparam int WordBits        = 32;
  localparam int ProdBits        = 2 * WordBits;
  localparam int SumBits         = ProdBits + 2;
  localparam int NumRows         = 4;
  localparam int NumCols         = 4;
  localparam int ScaleCols       = 3;
  localparam int FracBitsDefault = 16;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [SumBits-1:0]  sum_t;

  typedef enum logic [1:0] {
    CmdLoad      = 2'd0,
    CmdTransform = 2'd1,
    CmdTranslate = 2'd2,
    CmdScale     = 2'd3
  } cmd_e;

  // Coefficient store write controls
  typedef struct packed {
    logic       load;
    logic [1:0] col;
    logic       translate;
    logic       scale;
  } coef_wr_t;

  typedef struct packed {
    word_t value;
    logic  sat;
  } sat_t;

  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

  // Clamp a wide sum to the signed word range
  function automatic sat_t sat_word(input sum_t v);
    sat_t r;
    if (v[SumBits-1:WordBits-1] == '0 || v[SumBits-1:WordBits-1] == '1) begin
      r.value = v[WordBits-1:0];
      r.sat   = 1'b0;
    end else begin
      r.value = v[SumBits-1] ? WordMin : WordMax;
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/affine_matrix_vertex_transform_top.sv =====
// A transform request goes through the product register, then the output register.
// Throughput: loads and transforms one request per cycle while no transform waits
// at the output; translate and scale block requests until column writeback lands.
// Stages: sixteen products in four row lanes, then sum, clamp and output register.
// Reset (async, active low) sets the matrix to identity and empties the pipe.
module affine_matrix_vertex_transform_top import amvt_pkg::*; #(
  parameter int FracBits = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  column_i,
  input  word_t       in_x_i,
  input  word_t       in_y_i,
  input  word_t       in_z_i,
  input  word_t       in_w_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output word_t       out_x_o,
  output word_t       out_y_o,
  output word_t       out_z_o,
  output word_t       out_w_o,
  output logic        saturated_o
);

  cmd_e     cmd;
  logic     accept;
  logic     s1_valid_q;
  cmd_e     s1_cmd_q;
  logic     s1_xf;
  logic     out_free;
  logic     out_load;
  logic     out_valid_q;
  word_t    out_q [NumRows];
  logic     sat_q;
  coef_wr_t wr;
  word_t    vec  [NumCols];
  word_t    coef [NumCols][NumRows];
  word_t    row_coef [NumRows][NumCols];
  word_t    lane_sum [NumRows];
  logic     lane_sat [NumRows];
  word_t    lane_scl [NumRows][ScaleCols];
  logic     any_sat;

  assign cmd    = cmd_e'(command_i);
  assign vec[0] = in_x_i;
  assign vec[1] = in_y_i;
  assign vec[2] = in_z_i;
  assign vec[3] = in_w_i;

  // Pipe control: only a transform in stage one waits for the output register
  assign s1_xf      = s1_valid_q && (s1_cmd_q == CmdTransform);
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = s1_xf && out_free;
  assign in_ready_o = !s1_valid_q || out_load;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cmd_q   <= CmdLoad;
    end else if (accept && cmd != CmdLoad) begin
      s1_valid_q <= 1'b1;
      s1_cmd_q   <= cmd;
    end else if (!s1_xf || out_free) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Coefficient writes: loads at accept, writebacks from stage one
  always_comb begin
    wr.load      = accept && (cmd == CmdLoad);
    wr.col       = column_i;
    wr.translate = s1_valid_q && (s1_cmd_q == CmdTranslate);
    wr.scale     = s1_valid_q && (s1_cmd_q == CmdScale);
  end

  amvt_coeffs #(
    .FracBits (FracBits)
  ) u_coeffs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .ld_val_i (vec),
    .tr_val_i (lane_sum),
    .sc_val_i (lane_scl),
    .coef_o   (coef)
  );

  // Row lanes
  for (genvar r = 0; r < NumRows; r++) begin : g_lane
    for (genvar c = 0; c < NumCols; c++) begin : g_col
      assign row_coef[r][c] = coef[c][r];
    end

    amvt_lane #(
      .FracBits (FracBits)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (accept && cmd != CmdLoad),
      .coef_i    (row_coef[r]),
      .vec_i     (vec),
      .xf_sel_i  (s1_cmd_q == CmdTransform),
      .sum_o     (lane_sum[r]),
      .sum_sat_o (lane_sat[r]),
      .scl_o     (lane_scl[r])
    );
  end

  // Merge the lanes' clamp flags
  always_comb begin
    any_sat = 1'b0;
    for (int r = 0; r < NumRows; r++) begin
      any_sat = any_sat | lane_sat[r];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= lane_sum;
      sat_q <= any_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign out_w_o     = out_q[3];
  assign saturated_o = sat_q;

endmodule

// ===== hdl/amvt_lane.sv =====
// One row lane: four registered products, then shift, sum and saturate.
// Depends on amvt_pkg.
module amvt_lane import amvt_pkg::*; #(
  parameter int FracBits = FracBitsDefault
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t coef_i [NumCols],
  input  word_t vec_i  [NumCols],
  input  logic  xf_sel_i,
  output word_t sum_o,
  output logic  sum_sat_o,
  output word_t scl_o  [ScaleCols]
);

  prod_t prod_q [NumCols];
  word_t tcol_q;
  prod_t sh [NumCols];
  sum_t  term3;
  sum_t  sum;
  sat_t  sum_s;
  sat_t  scl_s [ScaleCols];

  // Product stage, payload only
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NumCols; c++) begin
        prod_q[c] <= ProdBits'(coef_i[c]) * ProdBits'(vec_i[c]);
      end
      tcol_q <= coef_i[NumCols-1];
    end
  end

  // Shift, sum and clamp
  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      sh[c] = prod_q[c] >>> FracBits;
    end
    // transform uses the w product, translate the old t coefficient
    term3 = xf_sel_i ? SumBits'(sh[NumCols-1]) : SumBits'(tcol_q);
    sum   = SumBits'(sh[0]) + SumBits'(sh[1]) + SumBits'(sh[2]) + term3;
    sum_s = sat_word(sum);
    for (int c = 0; c < ScaleCols; c++) begin
      scl_s[c] = sat_word(SumBits'(sh[c]));
      scl_o[c] = scl_s[c].value;
    end
  end

  assign sum_o     = sum_s.value;
  assign sum_sat_o = sum_s.sat;

endmodule

// ===== hdl/amvt_coeffs.sv =====
// Column-major 4x4 coefficient store, reset to identity.
// Depends on amvt_pkg.
module amvt_coeffs import amvt_pkg::*; #(
  parameter int FracBits = FracBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  coef_wr_t wr_i,
  input  word_t    ld_val_i [NumRows],
  input  word_t    tr_val_i [NumRows],
  input  word_t    sc_val_i [NumRows][ScaleCols],
  output word_t    coef_o   [NumCols][NumRows]
);

  localparam word_t CoefOne = word_t'(1) << FracBits;

  word_t coef_q [NumCols][NumRows];
  word_t coef_d [NumCols][NumRows];

  // Write merge: load, translation column or scaled i, j, k
  always_comb begin
    coef_d = coef_q;
    if (wr_i.load) begin
      for (int r = 0; r < NumRows; r++) begin
        coef_d[wr_i.col][r] = ld_val_i[r];
      end
    end
    if (wr_i.translate) begin
      for (int r = 0; r < NumRows; r++) begin
        coef_d[NumCols-1][r] = tr_val_i[r];
      end
    end
    if (wr_i.scale) begin
      for (int c = 0; c < ScaleCols; c++) begin
        for (int r = 0; r < NumRows; r++) begin
          coef_d[c][r] = sc_val_i[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCols; c++) begin
        for (int r = 0; r < NumRows; r++) begin
          coef_q[c][r] <= (c == r) ? CoefOne : '0;
        end
      end
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== hdl/amvt_checker.sv =====
// Port-level checks for the vertex transform top, bound to it below.
// Depends on amvt_pkg and affine_matrix_vertex_transform_top_macros.svh.
`include "affine_matrix_vertex_transform_top_macros.svh"

module amvt_checker import amvt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] command_i,
  input logic [1:0] column_i,
  input word_t      in_x_i,
  input word_t      in_y_i,
  input word_t      in_z_i,
  input word_t      in_w_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input word_t      out_x_o,
  input word_t      out_y_o,
  input word_t      out_z_o,
  input word_t      out_w_o,
  input logic       saturated_o
);

  logic                       in_wait;
  logic                       in_xf;
  logic                       in_upd;
  logic                       out_wait;
  logic [4+4*WordBits-1:0]    in_bus;
  logic [4*WordBits:0]        out_bus;

  // Handshake shorthands
  assign in_wait  = in_valid_i && !in_ready_o;
  assign out_wait = out_valid_o && !out_ready_i;
  assign in_xf    = in_valid_i && in_ready_o && (command_i == CmdTransform);
  assign in_upd   = in_valid_i && in_ready_o &&
                    (command_i == CmdTranslate || command_i == CmdScale);
  assign in_bus   = {command_i, column_i, in_x_i, in_y_i, in_z_i, in_w_i};
  assign out_bus  = {out_x_o, out_y_o, out_z_o, out_w_o, saturated_o};

  // A waiting request holds until taken
  `AMVT_ASSERT(a_in_hold, in_wait |=> in_valid_i && $stable(in_bus), "request not held")

  // A pending result holds until taken
  `AMVT_ASSERT(a_out_hold, out_wait |=> out_valid_o && $stable(out_bus), "result not held")

  // Nothing is shown while in reset
  `AMVT_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

  // A fresh result comes from a transform request that passed the product and output registers
  `AMVT_ASSERT(a_out_source, $rose(out_valid_o) |-> $past(in_xf, 2), "result with no transform")

  // Matrix updates hold off requests in the cycle after they are taken
  `AMVT_ASSERT(a_update_gap, in_upd |=> !in_ready_o, "request taken during matrix update")

endmodule

bind affine_matrix_vertex_transform_top amvt_checker u_amvt_checker (.*);
